[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, codes, types and an index helper for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Store geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	// front + count stays below 2*DEPTH
	localparam int SUM_W = IDX_W + 1;

	localparam int OP_W   = 3;
	localparam int STAT_W = 2;
	localparam int WORD_W = 32;

	// Opcodes
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted request
		logic execute;   // update indices, access the store
		logic load_out;  // move the result into the output register
	} deq_cmd_t;

	// Fold a sum below 2*DEPTH back into the store range
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] folded;
		folded = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
		return folded[IDX_W-1:0];
	endfunction

endpackage

[design/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: sequences accept, execute and result load, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output deq_pkg::deq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       req_xfer;
	logic       rsp_xfer;
	logic       out_free;

	assign req_stall = (state_q != S_IDLE);
	assign req_xfer  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_xfer  = rsp_valid_q && !rsp_stall;
	// output register can take a new result this cycle
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Commands
	always_comb begin
		cmd.capture  = req_xfer;
		cmd.execute  = (state_q == S_EXEC);
		cmd.load_out = (state_q == S_DONE) && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_xfer) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (rsp_xfer) rsp_valid_q <= 1'b0;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execute");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_DONE))
		else $error("execute did not advance to result load");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid_q)
		else $error("loaded result not presented");

endmodule

[design/deq_datapath.sv]
// ----------------------------------------------------------------------------
// deq_datapath
// Datapath: request latch, circular store with front index and count,
// status generation and the output register.
// ----------------------------------------------------------------------------
module deq_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deq_pkg::deq_cmd_t                 cmd,
	input  logic        [deq_pkg::OP_W-1:0]   opcode,
	input  logic signed [deq_pkg::WORD_W-1:0] push_value,
	output logic        [deq_pkg::STAT_W-1:0] status,
	output logic signed [deq_pkg::WORD_W-1:0] read_value
);

	logic [deq_pkg::WORD_W-1:0] mem [deq_pkg::DEPTH];

	logic [deq_pkg::OP_W-1:0]   op_q;
	logic [deq_pkg::WORD_W-1:0] value_q;
	logic [deq_pkg::IDX_W-1:0]  front_q;
	logic [deq_pkg::CNT_W-1:0]  count_q;
	logic [deq_pkg::STAT_W-1:0] stat_q;
	logic                       rd_ok_q;
	logic [deq_pkg::WORD_W-1:0] rd_data_q;
	logic [deq_pkg::STAT_W-1:0] status_q;
	logic [deq_pkg::WORD_W-1:0] read_value_q;

	logic                       is_push;
	logic                       is_read;
	logic                       at_front;
	logic                       removes;
	logic                       full;
	logic                       empty;
	logic [deq_pkg::SUM_W-1:0]  front_ext;
	logic [deq_pkg::SUM_W-1:0]  count_ext;
	logic [deq_pkg::IDX_W-1:0]  front_dec;
	logic [deq_pkg::IDX_W-1:0]  front_inc;
	logic [deq_pkg::IDX_W-1:0]  back_free;
	logic [deq_pkg::IDX_W-1:0]  back_last;
	logic [deq_pkg::IDX_W-1:0]  wr_addr;
	logic [deq_pkg::IDX_W-1:0]  rd_addr;
	logic [deq_pkg::STAT_W-1:0] stat_d;
	logic                       do_write;

	// Decode and index arithmetic
	always_comb begin
		is_push  = op_q inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK};
		is_read  = op_q inside {deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
			deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK};
		at_front = op_q inside {deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_POP_FRONT,
			deq_pkg::OP_PEEK_FRONT};
		removes  = op_q inside {deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK};
		full     = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
		empty    = (count_q == '0);

		front_ext = deq_pkg::SUM_W'(front_q);
		count_ext = deq_pkg::SUM_W'(count_q);
		front_dec = (front_q == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)
			: (front_q - 1'b1);
		front_inc = deq_pkg::wrap_idx(front_ext + 1'b1);
		back_free = deq_pkg::wrap_idx(front_ext + count_ext);
		back_last = deq_pkg::wrap_idx(front_ext + count_ext - 1'b1);

		wr_addr  = at_front ? front_dec : back_free;
		rd_addr  = at_front ? front_q : back_last;
		do_write = cmd.execute && is_push && !full;

		stat_d = deq_pkg::ST_OK;
		if (is_push && full) stat_d = deq_pkg::ST_FULL;
		else if (is_read && empty) stat_d = deq_pkg::ST_EMPTY;
	end

	// Request latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			value_q <= push_value;
		end
	end

	// Store: at most one write and one registered read per execute cycle
	always_ff @(posedge clk) begin
		if (do_write) mem[wr_addr] <= value_q;
		if (cmd.execute) rd_data_q <= mem[rd_addr];
	end

	// Front index and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.execute) begin
			if (is_push && !full) begin
				count_q <= count_q + 1'b1;
				if (at_front) front_q <= front_dec;
			end else if (removes && !empty) begin
				count_q <= count_q - 1'b1;
				if (at_front) front_q <= front_inc;
			end
		end
	end

	// Status of the executed request
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			stat_q  <= stat_d;
			rd_ok_q <= is_read && !empty;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q     <= stat_q;
			read_value_q <= rd_ok_q ? rd_data_q : '0;
		end
	end

	assign status     = status_q;
	assign read_value = read_value_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("element count beyond store depth");

	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		deq_pkg::SUM_W'(front_q) < deq_pkg::SUM_W'(deq_pkg::DEPTH))
		else $error("front index outside store");

endmodule

[design/double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Each request (push front/back, pop front/back, peek front/back) gives one
// response with a status (ok, empty, full) and the word read, zero unless a
// pop or peek succeeds. A request is latched, then updates the indices and
// accesses the store, then the store's registered read data is loaded into the
// output register. req_stall is high from each transfer until the result is
// loaded, so a new request is taken only once the last one is through. The
// output register lets the next request be accepted while a response waits; a
// response not yet taken holds the following one in its result-load state.
// Unused opcodes give ok and zero.
module double_ended_queue_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic        [deq_pkg::OP_W-1:0]   opcode,
	input  logic signed [deq_pkg::WORD_W-1:0] push_value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic        [deq_pkg::STAT_W-1:0] status,
	output logic signed [deq_pkg::WORD_W-1:0] read_value
);

	deq_pkg::deq_cmd_t cmd;

	// Sequencing
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Store and indices
	deq_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.push_value (push_value),
		.status     (status),
		.read_value (read_value)
	);

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended queue core. A short table of
// requests covers the empty, full and unused-opcode cases and the word
// extremes. Random bursts then fill, drain and churn the queue. Every response
// is compared with a local model of the circular store.
// ----------------------------------------------------------------------------
module tb_top;

	// Opcodes the core ignores
	localparam logic [deq_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [deq_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

	localparam int N_RANDOM = 1150;
	localparam int N_ROWS   = 17;

	typedef struct packed {
		logic [deq_pkg::STAT_W-1:0] status;
		logic [deq_pkg::WORD_W-1:0] word;
	} deq_result_t;

	// One row of the opening table; fixed_exp marks rows whose result is typed in
	typedef struct packed {
		logic [deq_pkg::OP_W-1:0]   op;
		logic [deq_pkg::WORD_W-1:0] value;
		logic [4:0]                 reps;
		logic                       fixed_exp;
		logic [deq_pkg::STAT_W-1:0] status;
		logic [deq_pkg::WORD_W-1:0] word;
	} stim_row_t;

	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              req_valid  = 1'b0;
	logic                              req_stall;
	logic [deq_pkg::OP_W-1:0]          opcode     = '0;
	logic signed [deq_pkg::WORD_W-1:0] push_value = '0;
	logic                              rsp_valid;
	logic                              rsp_stall  = 1'b0;
	logic [deq_pkg::STAT_W-1:0]        status;
	logic signed [deq_pkg::WORD_W-1:0] read_value;

	// Local copy of the queue
	logic [deq_pkg::WORD_W-1:0] deque_words [deq_pkg::DEPTH];
	int                         head_slot  = 0;
	int                         held_words = 0;

	deq_result_t pending_results [$];
	deq_result_t oldest;
	int          mismatch_count = 0;
	int          n_accepted     = 0;
	int          n_ok           = 0;
	int          n_empty        = 0;
	int          n_full         = 0;
	int          stall_left     = 0;
	int          quiet_left     = 0;

	stim_row_t dir_rows [N_ROWS];

	double_ended_queue_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.push_value (push_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.read_value (read_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the local queue and return its result
	function automatic deq_result_t deque_apply(input logic [deq_pkg::OP_W-1:0] op,
	                                            input logic [deq_pkg::WORD_W-1:0] val);
		deq_result_t r;
		int          slot;
		r.status = deq_pkg::ST_OK;
		r.word   = '0;
		case (op)
			deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
				if (held_words == deq_pkg::DEPTH) begin
					r.status = deq_pkg::ST_FULL;
				end else begin
					if (op == deq_pkg::OP_PUSH_FRONT) begin
						head_slot = (head_slot + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
						slot      = head_slot;
					end else begin
						slot = (head_slot + held_words) % deq_pkg::DEPTH;
					end
					deque_words[slot] = val;
					held_words++;
				end
			end
			deq_pkg::OP_POP_FRONT, deq_pkg::OP_PEEK_FRONT: begin
				if (held_words == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					r.word = deque_words[head_slot];
					if (op == deq_pkg::OP_POP_FRONT) begin
						head_slot = (head_slot + 1) % deq_pkg::DEPTH;
						held_words--;
					end
				end
			end
			deq_pkg::OP_POP_BACK, deq_pkg::OP_PEEK_BACK: begin
				if (held_words == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					r.word = deque_words[(head_slot + held_words - 1) % deq_pkg::DEPTH];
					if (op == deq_pkg::OP_POP_BACK)
						held_words--;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Optional idle gap, then one request transfer; queues the expected result
	task automatic transfer_request(input logic [deq_pkg::OP_W-1:0] op,
	                                input logic [deq_pkg::WORD_W-1:0] val,
	                                input bit idle_on, input bit fixed_exp,
	                                input logic [deq_pkg::STAT_W-1:0] fixed_status,
	                                input logic [deq_pkg::WORD_W-1:0] fixed_word);
		int          gap;
		deq_result_t predicted;
		gap = 0;
		if (idle_on) begin
			case ($urandom_range(0, 9))
				6, 7, 8: gap = $urandom_range(1, 3);
				9:       gap = $urandom_range(5, 30);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		opcode     <= op;
		push_value <= val;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = deque_apply(op, val);
		if (fixed_exp) begin
			predicted.status = fixed_status;
			predicted.word   = fixed_word;
		end
		pending_results.push_back(predicted);
		n_accepted++;
	endtask

	// Response side back-pressure: calm stretches, short stalls, a few long ones
	always @(posedge clk) begin
		if (quiet_left != 0) begin
			quiet_left <= quiet_left - 1;
			rsp_stall  <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			case ($urandom_range(0, 19))
				0:          quiet_left <= $urandom_range(50, 300);
				1:          stall_left <= $urandom_range(5, 30);
				2, 3, 4, 5: stall_left <= $urandom_range(1, 3);
				default: ;
			endcase
		end
	end

	// Response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("response transfer with none pending: status %0d read_value %h",
				       status, read_value);
				mismatch_count++;
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.status) begin
					$error("status mismatch: expected %0d, got %0d", oldest.status, status);
					mismatch_count++;
				end
				if (read_value !== oldest.word) begin
					$error("read_value mismatch: expected %h, got %h", oldest.word, read_value);
					mismatch_count++;
				end
				case (oldest.status)
					deq_pkg::ST_EMPTY: n_empty++;
					deq_pkg::ST_FULL:  n_full++;
					default:           n_ok++;
				endcase
			end
		end
	end

	initial begin : stimulus
		int                         mode;
		int                         burst_len;
		int                         n_sent;
		bit                         idle_on;
		logic [deq_pkg::OP_W-1:0]   op;
		logic [deq_pkg::WORD_W-1:0] val;

		// Empty checks, ignored opcodes, extremes, fill to full, push on full, then a peek and two pops
		dir_rows = '{
			'{deq_pkg::OP_POP_FRONT, 32'h0000_0000, 5'd1, 1'b1, deq_pkg::ST_EMPTY, 32'h0},
			'{deq_pkg::OP_POP_BACK, 32'h0000_0000, 5'd1, 1'b1, deq_pkg::ST_EMPTY, 32'h0},
			'{deq_pkg::OP_PEEK_FRONT, 32'hFFFF_FFFF, 5'd1, 1'b1, deq_pkg::ST_EMPTY, 32'h0},
			'{deq_pkg::OP_PEEK_BACK, 32'hFFFF_FFFF, 5'd1, 1'b1, deq_pkg::ST_EMPTY, 32'h0},
			'{OP_RSVD_6, 32'hFFFF_FFFF, 5'd1, 1'b1, deq_pkg::ST_OK, 32'h0},
			'{OP_RSVD_7, 32'h5A5A_A5A5, 5'd1, 1'b1, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 5'd1, 1'b1, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b1, deq_pkg::ST_OK,
				32'h8000_0000},
			'{deq_pkg::OP_PEEK_BACK, 32'h0000_0000, 5'd1, 1'b1, deq_pkg::ST_OK,
				32'h7FFF_FFFF},
			'{deq_pkg::OP_PUSH_BACK, 32'h0000_0000, 5'd7, 1'b0, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFF0, 5'd7, 1'b0, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_PUSH_FRONT, 32'h1234_5678, 5'd1, 1'b1, deq_pkg::ST_FULL, 32'h0},
			'{deq_pkg::OP_PUSH_BACK, 32'h8765_4321, 5'd1, 1'b1, deq_pkg::ST_FULL, 32'h0},
			'{deq_pkg::OP_PEEK_FRONT, 32'h0000_0000, 5'd1, 1'b0, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_POP_BACK, 32'h0000_0000, 5'd1, 1'b0, deq_pkg::ST_OK, 32'h0},
			'{deq_pkg::OP_POP_FRONT, 32'h0000_0000, 5'd1, 1'b0, deq_pkg::ST_OK, 32'h0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++)
				transfer_request(dir_rows[i].op, dir_rows[i].value + k, 1'b1,
				                 dir_rows[i].fixed_exp, dir_rows[i].status, dir_rows[i].word);
		end

		// Random bursts: push-heavy to reach full, pop-heavy to drain, or mixed
		n_sent = 0;
		while (n_sent < N_RANDOM) begin
			mode      = $urandom_range(0, 9);
			burst_len = $urandom_range(1, 40);
			idle_on   = ($urandom_range(0, 3) != 0);
			for (int k = 0; k < burst_len; k++) begin
				if (mode < 4)
					op = ($urandom_range(0, 3) != 0) ? deq_pkg::OP_W'($urandom_range(0, 1))
					                                 : deq_pkg::OP_W'($urandom_range(2, 5));
				else if (mode < 8)
					op = ($urandom_range(0, 3) != 0) ? deq_pkg::OP_W'($urandom_range(2, 5))
					                                 : deq_pkg::OP_W'($urandom_range(0, 1));
				else
					op = deq_pkg::OP_W'($urandom_range(0, 7));
				case ($urandom_range(0, 15))
					0:       val = 32'h0000_0000;
					1:       val = 32'hFFFF_FFFF;
					2:       val = 32'h8000_0000;
					3:       val = 32'h7FFF_FFFF;
					default: val = $urandom;
				endcase
				transfer_request(op, val, idle_on, 1'b0, deq_pkg::ST_OK, '0);
				if (op <= deq_pkg::OP_PEEK_BACK)
					n_sent++;
			end
		end
		req_valid <= 1'b0;

		// Drain outstanding responses, then watch for strays
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d requests; responses: %0d ok, %0d empty, %0d full.",
		         n_accepted, n_ok, n_empty, n_full);
		$display("Mismatches found: %0d.", mismatch_count);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timeout: %0d responses still pending.", pending_results.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
